[design/mcsb_pkg.sv]
package mcsb_pkg;

  // number format: signed fixed point, 48-bit word, 32 fraction bits
  localparam int WordW = 48;
  localparam int FracW = 32;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic [WordW-1:0]        mag_t;

  localparam word_t QHi = {1'b0, {(WordW-1){1'b1}}};
  localparam word_t QLo = {1'b1, {(WordW-1){1'b0}}};
  localparam word_t One = word_t'(64'd1 << FracW);
  localparam word_t Lsb = word_t'(1);

  // register map, selected by paddr[3]
  localparam logic RegGamma = 1'b0;
  localparam logic RegEmhd  = 1'b1;

  // reset values of the registers
  localparam logic [33:0] GammaReset = 34'd5726623061;
  localparam logic [35:0] EmhdReset  = 36'd4294967296;

  // magnitude of a signed word, most negative word gives 2^(WordW-1)
  function automatic mag_t mag(word_t v);
    mag_t m;
    m = v[WordW-1] ? mag_t'(-v) : mag_t'(v);
    return m;
  endfunction

  // saturating add
  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [WordW:0] s;
    word_t r;
    s = {a[WordW-1], a} + {b[WordW-1], b};
    if (s[WordW] != s[WordW-1]) r = s[WordW] ? QLo : QHi;
    else r = s[WordW-1:0];
    return r;
  endfunction

  // saturating subtract
  function automatic word_t sat_sub(word_t a, word_t b);
    logic signed [WordW:0] s;
    word_t r;
    s = {a[WordW-1], a} - {b[WordW-1], b};
    if (s[WordW] != s[WordW-1]) r = s[WordW] ? QLo : QHi;
    else r = s[WordW-1:0];
    return r;
  endfunction

endpackage

[design/mcsb_delay.sv]
module mcsb_delay #(
  parameter int Width = 48,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] tap_q [0:Depth-1];

  // shift line, moves only when the pipeline advances
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < Depth; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[Depth-1];

endmodule

[design/mcsb_mul.sv]
module mcsb_mul import mcsb_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  word_t a_i,
  input  word_t b_i,
  output word_t p_o
);

  localparam int HalfW = WordW / 2;

  logic [2*HalfW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic               neg_q;
  word_t              p_q;

  mag_t ma, mb;
  assign ma = mag(a_i);
  assign mb = mag(b_i);

  // stage 1: four half-width partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= ma[HalfW-1:0]      * mb[HalfW-1:0];
      p01_q <= ma[HalfW-1:0]      * mb[WordW-1:HalfW];
      p10_q <= ma[WordW-1:HalfW]  * mb[HalfW-1:0];
      p11_q <= ma[WordW-1:HalfW]  * mb[WordW-1:HalfW];
      neg_q <= a_i[WordW-1] ^ b_i[WordW-1];
    end
  end

  // stage 2: sum, drop fraction bits, saturate, apply sign
  logic [2*WordW-1:0]       prod;
  logic [2*HalfW:0]         mid;
  logic [2*WordW-FracW-1:0] sh;
  mag_t                     cap, m;

  always_comb begin
    mid  = {1'b0, p01_q} + {1'b0, p10_q};
    prod = ({{WordW{1'b0}}, p11_q} << WordW)
         + ({{(2*WordW-2*HalfW-1){1'b0}}, mid} << HalfW)
         + {{WordW{1'b0}}, p00_q};
    sh   = prod[2*WordW-1:FracW];
    cap  = neg_q ? mag_t'(QLo) : mag_t'(QHi);
    m    = (sh > {{(WordW-FracW){1'b0}}, cap}) ? cap : sh[WordW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= neg_q ? word_t'(-m) : word_t'(m);
    end
  end

  assign p_o = p_q;

endmodule

[design/mcsb_div.sv]
module mcsb_div import mcsb_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  word_t a_i,
  input  word_t b_i,
  output word_t q_o
);

  localparam int Steps = WordW;
  localparam int TopW  = WordW - FracW;

  mag_t rem_q  [0:Steps];
  mag_t low_q  [0:Steps];
  mag_t quo_q  [0:Steps];
  mag_t db_q   [0:Steps];
  logic neg_q  [0:Steps];
  logic az_q   [0:Steps];
  logic ovf_q  [0:Steps];
  word_t res_q;

  mag_t ma, mb;
  assign ma = mag(a_i);
  assign mb = mag(b_i);

  // entry: split the shifted dividend, flag quotients at or above 2^WordW
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {{TopW{1'b0}}, ma[WordW-1:TopW]};
      low_q[0] <= {ma[TopW-1:0], {FracW{1'b0}}};
      quo_q[0] <= '0;
      db_q[0]  <= mb;
      neg_q[0] <= a_i[WordW-1] ^ b_i[WordW-1];
      az_q[0]  <= (a_i == '0);
      ovf_q[0] <= ({{TopW{1'b0}}, ma[WordW-1:TopW]} >= mb);
    end
  end

  // one restoring step per stage
  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [WordW:0] t;
    logic           ge;
    assign t  = {rem_q[k], low_q[k][WordW-1]};
    assign ge = (t >= {1'b0, db_q[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? WordW'(t - {1'b0, db_q[k]}) : t[WordW-1:0];
        low_q[k+1] <= {low_q[k][WordW-2:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][WordW-2:0], ge};
        db_q[k+1]  <= db_q[k];
        neg_q[k+1] <= neg_q[k];
        az_q[k+1]  <= az_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  // saturate and sign the quotient
  mag_t cap, m;
  always_comb begin
    cap = neg_q[Steps] ? mag_t'(QLo) : mag_t'(QHi);
    if (ovf_q[Steps] || (quo_q[Steps] > cap)) m = cap;
    else m = quo_q[Steps];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (az_q[Steps]) res_q <= '0;
      else res_q <= neg_q[Steps] ? word_t'(-m) : word_t'(m);
    end
  end

  assign q_o = res_q;

endmodule

[design/mcsb_sqrt.sv]
module mcsb_sqrt import mcsb_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  word_t x_i,
  output word_t r_o
);

  // radicand is x << FracW, below 2^(WordW-1+FracW)
  localparam int RadW  = 2 * ((WordW + FracW + 1) / 2);
  localparam int Steps = RadW / 2;
  localparam int RemW  = Steps + 2;

  logic [RadW-1:0]  rad_q  [0:Steps];
  logic [RemW-1:0]  rem_q  [0:Steps];
  logic [Steps-1:0] root_q [0:Steps];
  logic             pos_q  [0:Steps];
  word_t            res_q;

  // entry
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= RadW'({x_i[WordW-2:0], {FracW{1'b0}}});
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      pos_q[0]  <= !x_i[WordW-1] && (x_i != '0);
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [RemW+1:0] t, trial;
    logic            ge;
    assign t     = {rem_q[k], rad_q[k][RadW-1:RadW-2]};
    assign trial = {2'b00, root_q[k], 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? RemW'(t - trial) : t[RemW-1:0];
        root_q[k+1] <= {root_q[k][Steps-2:0], ge};
        rad_q[k+1]  <= {rad_q[k][RadW-3:0], 2'b00};
        pos_q[k+1]  <= pos_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= pos_q[Steps] ? word_t'({{(WordW-Steps){1'b0}}, root_q[Steps]}) : '0;
    end
  end

  assign r_o = res_q;

endmodule

[design/mhd_char_speed_bounds_top.sv]
// channel   dir  beat width  fields
// s_axis    in   416 bits    nine point values (see tdata port)
// m_axis    out  96 bits     speed_min, speed_max
// apb       in   64 bits     adiabatic_index at 0x0, emhd_factor at 0x8
//
// a beat passes 158 register stages, counting the input register, to reach
// the output register; one beat enters per cycle while the output is not
// held, set by the fully pipelined multipliers, the three 48-step dividers
// and the 40-step square root
// reset clears valid line, presets config registers; payload is not reset
// a held output stalls the whole pipeline; bubbles in flight stay in place
module mhd_char_speed_bounds_top import mcsb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mag_pressure_sq[46:0], density[93:47], internal_energy[140:94],
  // sound_speed[173:141], vel_time[221:174], vel_dir[269:222],
  // metric_tt[317:270], metric_td[365:318], metric_dd[413:366], zero pad
  input  logic [415:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // speed_min[47:0], speed_max[94:48], zero pad
  output logic [95:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int LatM = 2;
  localparam int LatD = WordW + 2;
  localparam int LatS = (WordW + FracW + 1) / 2 + 2;

  localparam int TIn   = 1;
  localparam int TM1   = TIn + LatM;
  localparam int TDen  = TM1 + 1;
  localparam int TCs2a = TM1 + LatM;
  localparam int TCa2  = TDen + LatD;
  localparam int TCam  = TCa2 + LatM;
  localparam int TCs2  = TCam + 1;
  localparam int TSums = TM1 + 1;
  localparam int TMq   = TCs2 + LatM;
  localparam int TQ    = TMq + 1;
  localparam int TDen2 = TQ + 1;
  localparam int TMd   = TQ + LatM;
  localparam int TDisc = TMd + 2;
  localparam int TSq   = TDisc + LatS;
  localparam int TNum  = TSq + 1;
  localparam int TOut  = TNum + LatD + 1;

  // configuration registers
  logic [33:0] gam_q;
  logic [35:0] emhd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gam_q  <= GammaReset;
      emhd_q <= EmhdReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[3])
        RegGamma: gam_q  <= pwdata[33:0];
        RegEmhd:  emhd_q <= pwdata[35:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[3] == RegEmhd) ? {28'd0, emhd_q} : {30'd0, gam_q};

  // valid line and pipeline advance
  logic [TOut-1:0] vld_q;
  logic            en;

  assign en            = !vld_q[TOut-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[TOut-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOut-2:0], s_axis_tvalid};
    end
  end

  // input register
  word_t b2_q, rho_q, u_q, cs_q, bu_q, au_q, bsq_q, ab_q, asq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_q  <= {1'b0, s_axis_tdata[46:0]};
      rho_q <= {1'b0, s_axis_tdata[93:47]};
      u_q   <= {1'b0, s_axis_tdata[140:94]};
      cs_q  <= {15'd0, s_axis_tdata[173:141]};
      bu_q  <= s_axis_tdata[221:174];
      au_q  <= s_axis_tdata[269:222];
      bsq_q <= s_axis_tdata[317:270];
      ab_q  <= s_axis_tdata[365:318];
      asq_q <= s_axis_tdata[413:366];
    end
  end

  // first products
  word_t gu, ccs, bu2, au2, aubu;
  mcsb_mul u_mul_gu   (.clk_i, .en_i(en), .a_i({14'd0, gam_q}), .b_i(u_q), .p_o(gu));
  mcsb_mul u_mul_ccs  (.clk_i, .en_i(en), .a_i(cs_q), .b_i(cs_q), .p_o(ccs));
  mcsb_mul u_mul_bu2  (.clk_i, .en_i(en), .a_i(bu_q), .b_i(bu_q), .p_o(bu2));
  mcsb_mul u_mul_au2  (.clk_i, .en_i(en), .a_i(au_q), .b_i(au_q), .p_o(au2));
  mcsb_mul u_mul_aubu (.clk_i, .en_i(en), .a_i(au_q), .b_i(bu_q), .p_o(aubu));

  word_t rho_d, b2_d, bsq_d, ab_d, asq_d, b2_div;
  mcsb_delay #(.Width(WordW), .Depth(TM1 - TIn)) u_dl_rho
    (.clk_i, .en_i(en), .d_i(rho_q), .q_o(rho_d));
  mcsb_delay #(.Width(WordW), .Depth(TM1 - TIn)) u_dl_b2
    (.clk_i, .en_i(en), .d_i(b2_q), .q_o(b2_d));
  mcsb_delay #(.Width(WordW), .Depth(TM1 - TIn)) u_dl_bsq
    (.clk_i, .en_i(en), .d_i(bsq_q), .q_o(bsq_d));
  mcsb_delay #(.Width(WordW), .Depth(TM1 - TIn)) u_dl_ab
    (.clk_i, .en_i(en), .d_i(ab_q), .q_o(ab_d));
  mcsb_delay #(.Width(WordW), .Depth(TM1 - TIn)) u_dl_asq
    (.clk_i, .en_i(en), .d_i(asq_q), .q_o(asq_d));
  mcsb_delay #(.Width(WordW), .Depth(TDen - TIn)) u_dl_b2div
    (.clk_i, .en_i(en), .d_i(b2_q), .q_o(b2_div));

  // alfven denominator and metric sums
  word_t den1_q, sbsq_q, sab_q, sasq_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      den1_q <= sat_add(sat_add(rho_d, gu), b2_d);
      sbsq_q <= sat_add(bsq_d, bu2);
      sab_q  <= sat_add(ab_d, aubu);
      sasq_q <= sat_add(asq_d, au2);
    end
  end

  // alfven speed squared and scaled sound speed squared
  word_t ca2, cs2a, cs2a_d;
  mcsb_div u_div_ca2 (.clk_i, .en_i(en), .a_i(b2_div), .b_i(den1_q), .q_o(ca2));
  mcsb_mul u_mul_emhd (.clk_i, .en_i(en), .a_i(ccs), .b_i({12'd0, emhd_q}), .p_o(cs2a));
  mcsb_delay #(.Width(WordW), .Depth(TCa2 - TCs2a)) u_dl_cs2a
    (.clk_i, .en_i(en), .d_i(cs2a), .q_o(cs2a_d));

  // relativistic combination, clamp to one
  word_t cam, csum_q, csum2_q, cs2_q, cs2_n;
  mcsb_mul u_mul_cam (.clk_i, .en_i(en), .a_i(cs2a_d), .b_i(ca2), .p_o(cam));

  always_comb begin
    cs2_n = sat_sub(csum2_q, cam);
    if (cs2_n > One) cs2_n = One;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      csum_q  <= sat_add(cs2a_d, ca2);
      csum2_q <= csum_q;
      cs2_q   <= cs2_n;
    end
  end

  // quadratic coefficients
  word_t sbsq_d, sab_d, sasq_d, bu2_d, aubu_d, au2_d, mbsq, mab, masq;
  mcsb_delay #(.Width(WordW), .Depth(TCs2 - TSums)) u_dl_sbsq
    (.clk_i, .en_i(en), .d_i(sbsq_q), .q_o(sbsq_d));
  mcsb_delay #(.Width(WordW), .Depth(TCs2 - TSums)) u_dl_sab
    (.clk_i, .en_i(en), .d_i(sab_q), .q_o(sab_d));
  mcsb_delay #(.Width(WordW), .Depth(TCs2 - TSums)) u_dl_sasq
    (.clk_i, .en_i(en), .d_i(sasq_q), .q_o(sasq_d));
  mcsb_delay #(.Width(WordW), .Depth(TMq - TM1)) u_dl_bu2
    (.clk_i, .en_i(en), .d_i(bu2), .q_o(bu2_d));
  mcsb_delay #(.Width(WordW), .Depth(TMq - TM1)) u_dl_aubu
    (.clk_i, .en_i(en), .d_i(aubu), .q_o(aubu_d));
  mcsb_delay #(.Width(WordW), .Depth(TMq - TM1)) u_dl_au2
    (.clk_i, .en_i(en), .d_i(au2), .q_o(au2_d));

  mcsb_mul u_mul_bsq (.clk_i, .en_i(en), .a_i(sbsq_d), .b_i(cs2_q), .p_o(mbsq));
  mcsb_mul u_mul_ab  (.clk_i, .en_i(en), .a_i(sab_d),  .b_i(cs2_q), .p_o(mab));
  mcsb_mul u_mul_asq (.clk_i, .en_i(en), .a_i(sasq_d), .b_i(cs2_q), .p_o(masq));

  word_t qa_q, qb_q, qc_q, qb_n;
  assign qb_n = sat_sub(aubu_d, mab);

  always_ff @(posedge clk_i) begin
    if (en) begin
      qa_q <= sat_sub(bu2_d, mbsq);
      qb_q <= sat_add(qb_n, qb_n);
      qc_q <= sat_sub(au2_d, masq);
    end
  end

  // discriminant
  word_t ac, bb, bb_q, d4_q, disc_q, disc_n, ac2;
  mcsb_mul u_mul_ac (.clk_i, .en_i(en), .a_i(qa_q), .b_i(qc_q), .p_o(ac));
  mcsb_mul u_mul_bb (.clk_i, .en_i(en), .a_i(qb_q), .b_i(qb_q), .p_o(bb));
  assign ac2 = sat_add(ac, ac);

  always_comb begin
    disc_n = sat_sub(bb_q, d4_q);
    if (disc_n < Lsb) disc_n = Lsb;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d4_q   <= sat_add(ac2, ac2);
      bb_q   <= bb;
      disc_q <= disc_n;
    end
  end

  // root, doubled leading coefficient, numerators
  word_t droot, den2_q, den2_d, qb_d, den_q, nmin_q, nmax_q;
  mcsb_sqrt u_sqrt (.clk_i, .en_i(en), .x_i(disc_q), .r_o(droot));

  always_ff @(posedge clk_i) begin
    if (en) begin
      den2_q <= sat_add(qa_q, qa_q);
    end
  end

  mcsb_delay #(.Width(WordW), .Depth(TSq - TDen2)) u_dl_den
    (.clk_i, .en_i(en), .d_i(den2_q), .q_o(den2_d));
  mcsb_delay #(.Width(WordW), .Depth(TSq - TQ)) u_dl_qb
    (.clk_i, .en_i(en), .d_i(qb_q), .q_o(qb_d));

  always_ff @(posedge clk_i) begin
    if (en) begin
      nmin_q <= sat_sub(qb_d, droot);
      nmax_q <= sat_add(qb_d, droot);
      den_q  <= den2_d;
    end
  end

  // speeds, forced away from zero
  word_t smin, smax, smin_q, smax_q;
  mcsb_div u_div_min (.clk_i, .en_i(en), .a_i(nmin_q), .b_i(den_q), .q_o(smin));
  mcsb_div u_div_max (.clk_i, .en_i(en), .a_i(nmax_q), .b_i(den_q), .q_o(smax));

  always_ff @(posedge clk_i) begin
    if (en) begin
      smin_q <= (smin > -Lsb) ? -Lsb : smin;
      smax_q <= (smax < Lsb) ? Lsb : smax;
    end
  end

  assign m_axis_tdata = {1'b0, smax_q[WordW-2:0], smin_q};

  // checks
  a_min_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47])
    else $error("speed_min not negative");

  a_max_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[94:48] != 47'd0))
    else $error("speed_max not positive");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("held beat lost");

endmodule

[tb/sv/tb_mhd_char_speed_bounds_top.sv]
module tb_mhd_char_speed_bounds_top;
  import mcsb_pkg::*;

  localparam int PipeLat = 158;
  localparam longint CycleLimit = 400000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [415:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [63:0]  pwdata;
  logic [63:0]  prdata;
  logic         pready;

  // one grid point as it travels on the input bus
  typedef struct packed {
    logic [47:0] metric_dd;
    logic [47:0] metric_td;
    logic [47:0] metric_tt;
    logic [47:0] vel_dir;
    logic [47:0] vel_time;
    logic [32:0] sound_speed;
    logic [46:0] internal_energy;
    logic [46:0] density;
    logic [46:0] mag_pressure_sq;
  } point_t;

  typedef struct packed {
    logic [46:0] speed_max;
    logic [47:0] speed_min;
  } bounds_t;

  bounds_t     bounds_q[$];
  logic [33:0] gamma_cfg;
  logic [35:0] emhd_cfg;
  int          err_cnt;
  longint      cyc_cnt;
  bit          out_stall_en;
  int          stall_left;

  mhd_char_speed_bounds_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // fixed-point helpers, saturating to the word range
  function automatic word_t fx_mul(word_t a, word_t b);
    logic [95:0] p;
    logic [63:0] cap;
    logic        neg;
    logic [47:0] m;
    neg = a[47] ^ b[47];
    cap = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
    p = ({48'd0, mag(a)} * {48'd0, mag(b)}) >> FracW;
    m = (p > {32'd0, cap}) ? cap[47:0] : p[47:0];
    return neg ? word_t'(-m) : word_t'(m);
  endfunction

  function automatic word_t fx_div(word_t a, word_t b);
    logic [95:0] q;
    logic [63:0] cap;
    logic        neg;
    logic [47:0] m;
    if (b == 0) begin
      if (a == 0) return 0;
      return a[47] ? QLo : QHi;
    end
    neg = a[47] ^ b[47];
    cap = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
    q = ({48'd0, mag(a)} << FracW) / {48'd0, mag(b)};
    m = (q > {32'd0, cap}) ? cap[47:0] : q[47:0];
    return neg ? word_t'(-m) : word_t'(m);
  endfunction

  function automatic word_t fx_sqrt(word_t x);
    logic [95:0] n;
    logic [63:0] r;
    logic [63:0] t;
    if (x <= 0) return 0;
    n = {48'd0, x} << FracW;
    r = 0;
    for (int i = 47; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({32'd0, t} * {32'd0, t} <= {32'd0, n}) r = t;
    end
    if (r > 64'h7FFF_FFFF_FFFF) r = 64'h7FFF_FFFF_FFFF;
    return word_t'(r);
  endfunction

  function automatic word_t clip_u(logic [47:0] v);
    return v[47] ? QHi : word_t'(v);
  endfunction

  // fast magnetosonic speed bounds of one point
  function automatic bounds_t calc_bounds(point_t p);
    word_t gam, emhd, ca2, cs2, bu, au, bu2, au2, aubu, qa, qb, qc, disc, d, den;
    word_t smin, smax;
    bounds_t r;
    gam  = word_t'({14'd0, gamma_cfg});
    emhd = clip_u({12'd0, emhd_cfg});
    bu = p.vel_time;
    au = p.vel_dir;
    ca2 = fx_div(word_t'({1'b0, p.mag_pressure_sq}),
                 sat_add(sat_add(word_t'({1'b0, p.density}),
                                 fx_mul(gam, word_t'({1'b0, p.internal_energy}))),
                         word_t'({1'b0, p.mag_pressure_sq})));
    cs2 = fx_mul(fx_mul(word_t'({15'd0, p.sound_speed}), word_t'({15'd0, p.sound_speed})),
                 emhd);
    cs2 = sat_sub(sat_add(cs2, ca2), fx_mul(cs2, ca2));
    if (cs2 > One) cs2 = One;
    bu2  = fx_mul(bu, bu);
    au2  = fx_mul(au, au);
    aubu = fx_mul(au, bu);
    qa = sat_sub(bu2, fx_mul(sat_add(word_t'(p.metric_tt), bu2), cs2));
    qb = sat_sub(aubu, fx_mul(sat_add(word_t'(p.metric_td), aubu), cs2));
    qb = sat_add(qb, qb);
    qc = sat_sub(au2, fx_mul(sat_add(word_t'(p.metric_dd), au2), cs2));
    disc = fx_mul(qa, qc);
    disc = sat_add(disc, disc);
    disc = sat_add(disc, disc);
    disc = sat_sub(fx_mul(qb, qb), disc);
    if (disc < Lsb) disc = Lsb;
    d = fx_sqrt(disc);
    den = sat_add(qa, qa);
    smin = fx_div(sat_sub(qb, d), den);
    smax = fx_div(sat_add(qb, d), den);
    if (smin > -Lsb) smin = -Lsb;
    if (smax < Lsb) smax = Lsb;
    r.speed_min = smin;
    r.speed_max = smax[46:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_cnt++;
  endtask

  // cycle limit
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side: random stalls when enabled, mostly short and a few long, and result check
  always @(posedge clk_i) begin
    bounds_t got;
    bounds_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[94:0];
        if (bounds_q.size() == 0) begin
          $display("unexpected beat %h", m_axis_tdata);
          err_cnt++;
        end else begin
          want = bounds_q.pop_front();
          if (got.speed_min !== want.speed_min)
            report_mismatch("speed_min", got.speed_min, want.speed_min);
          if (got.speed_max !== want.speed_max)
            report_mismatch("speed_max", {1'b0, got.speed_max}, {1'b0, want.speed_max});
        end
        if (m_axis_tdata[95] !== 1'b0) report_mismatch("pad", 48'(m_axis_tdata[95]), 48'd0);
      end
      if (!out_stall_en) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 5) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    repeat (n) @(posedge clk_i);
  endtask

  // valid stays high after a beat until the next beat or a gap replaces it
  task automatic send_point(point_t p, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      idle_gap();
    end
    bounds_q.push_back(calc_bounds(p));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, p};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (bounds_q.size() != 0) @(posedge clk_i);
    repeat (PipeLat + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic reg_sel, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == RegGamma) gamma_cfg = val[33:0];
    else emhd_cfg = val[35:0];
    @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()} >> 16);
  endfunction

  // physically plausible point: small velocities, metric near flat
  function automatic point_t rand_physical();
    point_t p;
    p.mag_pressure_sq = 47'($urandom_range(0, 1 << 20)) << 12;
    p.density         = 47'($urandom_range(1, 1 << 20)) << 12;
    p.internal_energy = 47'($urandom_range(0, 1 << 20)) << 12;
    p.sound_speed     = 33'($urandom_range(0, 32'hFFFF_FFFF));
    p.vel_time        = 48'(64'd1 << 32) + 48'($urandom_range(0, 1 << 30));
    p.vel_dir         = 48'($signed($urandom_range(0, 1 << 31)) - (1 << 30));
    p.metric_tt       = -48'(64'd1 << 32) + 48'($urandom_range(0, 1 << 28));
    p.metric_td       = 48'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
    p.metric_dd       = 48'(64'd1 << 32) + 48'($urandom_range(0, 1 << 28));
    return p;
  endfunction

  function automatic point_t rand_raw();
    point_t p;
    logic [47:0] r0, r1, r2;
    r0 = rand48();
    r1 = rand48();
    r2 = rand48();
    p = {rand48(), rand48(), rand48(), rand48(), rand48(), 33'(rand48()),
         r0[46:0], r1[46:0], r2[46:0]};
    if (p.sound_speed > 33'h1_0000_0000) p.sound_speed = 33'h1_0000_0000;
    return p;
  endfunction

  task automatic test_directed();
    point_t p;
    p = '0;
    send_point(p, 0);
    p = '1;
    p.sound_speed = 33'h1_0000_0000;
    send_point(p, 0);
    // extremes of signed fields
    p = '0;
    p.vel_time = 48'h8000_0000_0000; p.vel_dir = 48'h7FFF_FFFF_FFFF;
    p.metric_tt = 48'h8000_0000_0000; p.metric_td = 48'h7FFF_FFFF_FFFF;
    p.metric_dd = 48'h8000_0000_0000;
    send_point(p, 0);
    // zero denominator, zero dividend
    p = '0; p.density = 1;
    send_point(p, 0);
    // magnetic dominated, sound speed one
    p = rand_physical(); p.mag_pressure_sq = '1; p.sound_speed = 33'h1_0000_0000;
    send_point(p, 0);
    // negative discriminant floors to one lsb
    p = rand_physical(); p.metric_tt = 48'h0001_0000_0000; p.metric_dd = 48'h0001_0000_0000;
    send_point(p, 0);
    for (int i = 0; i < 14; i++) send_point(i[0] ? rand_raw() : rand_physical(), 0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_point(($urandom_range(0, 3) != 0) ? rand_physical()
                                           : rand_raw(), 1);
  endtask

  task automatic test_config();
    write_reg(RegGamma, 64'd0);
    write_reg(RegEmhd, 64'd0);
    test_random(20);
    drain();
    write_reg(RegGamma, 64'd12884901888);
    write_reg(RegEmhd, 64'd34359738368);
    test_random(20);
    drain();
    write_reg(RegGamma, 64'(34'h3_FFFF_FFFF));
    write_reg(RegEmhd, 64'(36'hF_FFFF_FFFF));
    test_random(20);
    drain();
    write_reg(RegGamma, 64'(GammaReset));
    write_reg(RegEmhd, 64'(EmhdReset));
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_cnt = 0;
    cyc_cnt = 0;
    out_stall_en = 1'b0;
    stall_left = 0;
    gamma_cfg = GammaReset;
    emhd_cfg = EmhdReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain();
    test_config();
    out_stall_en = 1'b1;
    test_random(150);
    drain();
    test_random(150);
    drain();
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
